// ===== hdl/pdfe_pkg.sv =====
// Shared types and constants for the pulse-distance frame encoder.
package pdfe_pkg;

	// command codes carried in the input tuser
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PULSE     = 2'd0;
	localparam logic [1:0] REG_ZERO_GAP  = 2'd1;
	localparam logic [1:0] REG_ONE_GAP   = 2'd2;
	localparam logic [1:0] REG_FRAME_GAP = 2'd3;

	localparam logic [15:0] PULSE_RST     = 16'd100;
	localparam logic [15:0] ZERO_GAP_RST  = 16'd200;
	localparam logic [15:0] ONE_GAP_RST   = 16'd400;
	localparam logic [15:0] FRAME_GAP_RST = 16'd1000;

	// sequence steps
	localparam logic [2:0] STEP_START_PULSE = 3'd0;
	localparam logic [2:0] STEP_START_GAP   = 3'd1;
	localparam logic [2:0] STEP_BIT_PULSE   = 3'd2;
	localparam logic [2:0] STEP_BIT_GAP     = 3'd3;
	localparam logic [2:0] STEP_STOP_PULSE  = 3'd4;
	localparam logic [2:0] STEP_STOP_GAP    = 3'd5;

	// result of one accepted word, before the payload bit is known
	typedef struct packed {
		logic        valid;
		logic        pin;
		logic        use_bit;
		logic [2:0]  bit_sel;
		logic [15:0] delay;
		logic        done;
	} seq_res_t;

endpackage

// ===== hdl/pdfe_seq.sv =====
// Frame sequencer: step, bit counter and run flag, updated once per accepted word.
module pdfe_seq #(
	parameter int MAX_BYTES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  logic [1:0]         cmd,
	input  logic [7:0]         bit_count,
	input  logic [15:0]        pulse_ticks,
	input  logic [15:0]        frame_gap_ticks,
	output pdfe_pkg::seq_res_t res,
	output logic [4:0]         rd_pos
);

	localparam int CAP = (8 * MAX_BYTES > 255) ? 255 : 8 * MAX_BYTES;

	logic [2:0] step_q, step_d;
	logic [7:0] bits_sent_q, bits_sent_d;
	logic [7:0] frame_bits_q, frame_bits_d;
	logic       running_q, running_d;

	// payload byte for the bit about to be sent
	assign rd_pos = bits_sent_q[7:3];

	always_comb begin
		step_d       = step_q;
		bits_sent_d  = bits_sent_q;
		frame_bits_d = frame_bits_q;
		running_d    = running_q;
		res          = '0;
		if (acc && cmd == pdfe_pkg::CMD_START && !running_q) begin
			frame_bits_d = (bit_count > 8'(CAP)) ? 8'(CAP) : bit_count;
			bits_sent_d  = '0;
			step_d       = pdfe_pkg::STEP_START_PULSE;
			running_d    = 1'b1;
			res.valid    = 1'b1;
			res.delay    = pulse_ticks;
		end else if (acc && cmd == pdfe_pkg::CMD_EVENT && running_q) begin
			res.valid = 1'b1;
			case (step_q)
				pdfe_pkg::STEP_START_PULSE: begin
					bits_sent_d = '0;
					step_d      = pdfe_pkg::STEP_START_GAP;
					res.pin     = 1'b1;
					res.delay   = pulse_ticks;
				end
				pdfe_pkg::STEP_START_GAP: begin
					step_d    = pdfe_pkg::STEP_BIT_PULSE;
					res.delay = frame_gap_ticks;
				end
				pdfe_pkg::STEP_BIT_PULSE: begin
					step_d    = (bits_sent_q >= frame_bits_q) ? pdfe_pkg::STEP_STOP_PULSE
						: pdfe_pkg::STEP_BIT_GAP;
					res.pin   = 1'b1;
					res.delay = pulse_ticks;
				end
				pdfe_pkg::STEP_BIT_GAP: begin
					// gap length resolved downstream once the byte is read
					res.use_bit = 1'b1;
					res.bit_sel = bits_sent_q[2:0];
					bits_sent_d = bits_sent_q + 8'd1;
					step_d      = pdfe_pkg::STEP_BIT_PULSE;
				end
				pdfe_pkg::STEP_STOP_PULSE: begin
					step_d    = pdfe_pkg::STEP_STOP_GAP;
					res.delay = frame_gap_ticks;
				end
				default: begin
					step_d    = pdfe_pkg::STEP_START_PULSE;
					running_d = 1'b0;
					res.done  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= '0;
			bits_sent_q  <= '0;
			frame_bits_q <= '0;
			running_q    <= 1'b0;
		end else begin
			step_q       <= step_d;
			bits_sent_q  <= bits_sent_d;
			frame_bits_q <= frame_bits_d;
			running_q    <= running_d;
		end
	end

`ifndef SYNTH
	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.done |=> !running_q)
		else $error("frame end did not return to idle");
	a_start_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == pdfe_pkg::CMD_START && running_q |-> !res.valid)
		else $error("start accepted while running");
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> bits_sent_q <= frame_bits_q)
		else $error("bit counter passed frame length");
`endif

endmodule

// ===== hdl/pulse_distance_frame_encoder_unit.sv =====
// Pulse-distance frame encoder top level: config, payload memory and output pipeline.
// Input stream: tuser carries the command (load byte, start frame, timer event),
// tdata the load slot, load byte and bit count. Loads fill a 16-slot payload
// memory and give no word out; a start while idle gives one word (pin low, delay
// of one pulse); each timer event while running gives one word with the pin level
// to drive and the ticks to the next compare event. The last event of a frame
// returns pin low, delay 0 and tlast set; the block is then idle.
// Path: a result word is registered in the sequencer/memory read stage, then in the
// output register, and is valid on the output from there.
// Throughput: one input word per cycle when not stalled; sequencer state sits in flops
// and the payload memory is read once per word on its single synchronous read port.
// When the output is stalled the two stages fill and tready drops; the output
// word holds until taken. Configuration writes take effect on the next cycle.
// Reset clears the sequencer to idle and restores default tick values; the payload
// memory is not cleared, and a slot must be loaded before a frame sends its bits.
module pulse_distance_frame_encoder_unit #(
	parameter int MAX_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // byte_index[3:0], byte_value[11:4], bit_count[19:12]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // pin_level[0], next_delay[16:1]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	logic [15:0] pulse_q, zero_gap_q, one_gap_q, frame_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q     <= pdfe_pkg::PULSE_RST;
			zero_gap_q  <= pdfe_pkg::ZERO_GAP_RST;
			one_gap_q   <= pdfe_pkg::ONE_GAP_RST;
			frame_gap_q <= pdfe_pkg::FRAME_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pdfe_pkg::REG_PULSE:     pulse_q     <= cfg_data;
				pdfe_pkg::REG_ZERO_GAP:  zero_gap_q  <= cfg_data;
				pdfe_pkg::REG_ONE_GAP:   one_gap_q   <= cfg_data;
				pdfe_pkg::REG_FRAME_GAP: frame_gap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [3:0] byte_index;
	logic [7:0] byte_value;
	logic [7:0] bit_count;
	logic [1:0] cmd;

	assign byte_index = s_axis_tdata[3:0];
	assign byte_value = s_axis_tdata[11:4];
	assign bit_count  = s_axis_tdata[19:12];
	assign cmd        = s_axis_tuser;

	logic valid_s1, valid_s2, adv1, acc;

	assign adv1          = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv1;
	assign acc           = s_axis_tvalid && s_axis_tready;

	pdfe_pkg::seq_res_t seq_res;
	logic [4:0]         rd_pos;

	pdfe_seq #(
		.MAX_BYTES(MAX_BYTES)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.acc            (acc),
		.cmd            (cmd),
		.bit_count      (bit_count),
		.pulse_ticks    (pulse_q),
		.frame_gap_ticks(frame_gap_q),
		.res            (seq_res),
		.rd_pos         (rd_pos)
	);

	// payload memory: one write port for loads, one registered read port
	logic [7:0]    mem [MAX_BYTES];
	logic [7:0]    wr_idx, rd_idx;
	logic          wr_ok, rd_ok;
	logic [AW-1:0] wr_addr, rd_addr;

	assign wr_idx  = {4'b0000, byte_index};
	assign rd_idx  = {3'b000, rd_pos};
	assign wr_ok   = wr_idx < 8'(MAX_BYTES);
	assign rd_ok   = rd_idx < 8'(MAX_BYTES);
	assign wr_addr = wr_idx[AW-1:0];
	assign rd_addr = rd_idx[AW-1:0];

	pdfe_pkg::seq_res_t res_s1;
	logic [7:0]         byte_s1;
	logic               rd_ok_s1;

	always_ff @(posedge clk) begin
		if (acc && cmd == pdfe_pkg::CMD_LOAD && wr_ok) begin
			mem[wr_addr] <= byte_value;
		end
		if (acc) begin
			byte_s1  <= mem[rd_addr];
			rd_ok_s1 <= rd_ok;
			res_s1   <= seq_res;
		end
	end

	logic        bit_s1;
	logic [15:0] delay_s1;
	logic        pin_s2, done_s2;
	logic [15:0] delay_s2;

	assign bit_s1   = rd_ok_s1 && byte_s1[res_s1.bit_sel];
	assign delay_s1 = !res_s1.use_bit ? res_s1.delay : (bit_s1 ? one_gap_q : zero_gap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= seq_res.valid;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pin_s2   <= res_s1.pin;
			delay_s2 <= delay_s1;
			done_s2  <= res_s1.done;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'b0000000, delay_s2, pin_s2};
	assign m_axis_tlast  = done_s2;

`ifndef SYNTH
	a_done_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[16:0] == 17'd0)
		else $error("frame end word must carry pin low and zero delay");
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cmd == pdfe_pkg::CMD_LOAD |-> !seq_res.valid)
		else $error("load produced a result");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled with room in the pipeline");
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv1 |=> valid_s1)
		else $error("stage one word dropped while stalled");
`endif

endmodule
